// ===== hdl/rapf_pkg.sv =====
// Package: shared types, register map, symbol codes and the base encoder for the pattern finder.
package rapf_pkg;

    // Configuration port geometry
    localparam int AddrBits = 6;
    localparam int DataBits = 64;
    localparam int LenBits  = 6;
    localparam int ModeBits = 3;
    localparam int OutPosBits = 32;
    localparam int PatWords = 4;
    localparam int PatBytes = 32;

    // Register indexes (byte address = 8 * index)
    localparam logic [2:0] REG_ALPHABET_MODE  = 3'd0;
    localparam logic [2:0] REG_PATTERN_LENGTH = 3'd1;
    localparam logic [2:0] REG_PATTERN_WORD_0 = 3'd2;
    localparam logic [2:0] REG_PATTERN_WORD_1 = 3'd3;
    localparam logic [2:0] REG_PATTERN_WORD_2 = 3'd4;
    localparam logic [2:0] REG_PATTERN_WORD_3 = 3'd5;

    // Alphabet modes
    localparam logic [ModeBits-1:0] MODE_TWO_LETTER   = 3'd2;
    localparam logic [ModeBits-1:0] MODE_THREE_LETTER = 3'd3;
    localparam logic [ModeBits-1:0] MODE_NO_REDUCTION = 3'd4;

    // ASCII codes
    localparam logic [7:0] CHR_A     = 8'h41;
    localparam logic [7:0] CHR_C     = 8'h43;
    localparam logic [7:0] CHR_G     = 8'h47;
    localparam logic [7:0] CHR_T     = 8'h54;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_TWO   = 8'h32;
    localparam logic [7:0] CHR_LOW_A = 8'h61;
    localparam logic [7:0] CHR_LOW_Z = 8'h7a;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // Control passed from the register block to the datapath
    typedef struct packed {
        logic [ModeBits-1:0] mode;     // alphabet mode
        logic [LenBits-1:0]  len_c;    // pattern length clamped to the window
        logic                len_zero; // empty pattern: never matches
        logic [LenBits-1:0]  len_m1;   // clamped length minus one
    } t_match_ctrl;

    // Upper-case a letter, then reduce it under the selected alphabet
    function automatic logic [7:0] encode_base(input logic [7:0] b,
                                               input logic [ModeBits-1:0] mode);
        logic [7:0] c;
        logic [7:0] r;
        c = b;
        if (b >= CHR_LOW_A && b <= CHR_LOW_Z) begin
            c = b - CASE_GAP;
        end
        r = c;
        if (mode == MODE_TWO_LETTER) begin
            if (c == CHR_A || c == CHR_G) begin
                r = CHR_ZERO;
            end else if (c == CHR_C || c == CHR_T) begin
                r = CHR_ONE;
            end
        end else if (mode == MODE_THREE_LETTER) begin
            if (c == CHR_A) begin
                r = CHR_ZERO;
            end else if (c == CHR_G) begin
                r = CHR_ONE;
            end else if (c == CHR_C || c == CHR_T) begin
                r = CHR_TWO;
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/rapf_cfg.sv =====
// Register block: APB-style configuration registers and the aligned compare pattern.
module rapf_cfg import rapf_pkg::*; #(
    parameter int PATTERN_MAX = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [AddrBits-1:0]      paddr,
    input  logic [DataBits-1:0]      pwdata,
    output logic [DataBits-1:0]      prdata,
    output logic                     pready,
    output t_match_ctrl              o_ctrl,
    output logic [PATTERN_MAX*8-1:0] o_pattern,  // byte j compares with window entry j
    output logic [PATTERN_MAX-1:0]   o_mask      // entries that take part in the compare
);

    logic [ModeBits-1:0]       r_mode;
    logic [LenBits-1:0]        r_len;
    logic [DataBits-1:0]       r_word [PatWords];
    logic [PatBytes*8-1:0]     pat_all;
    logic [2:0]                reg_idx;
    logic                      wr_en;
    logic [LenBits-1:0]        len_c;
    logic [PATTERN_MAX*8-1:0]  n_pattern;
    logic [PATTERN_MAX-1:0]    n_mask;
    logic [PATTERN_MAX*8-1:0]  r_pattern;
    logic [PATTERN_MAX-1:0]    r_mask;

    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrBits-1:3];
    assign wr_en   = psel && penable && pwrite && pready;
    assign pat_all = {r_word[3], r_word[2], r_word[1], r_word[0]};

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NO_REDUCTION;
            r_len  <= LenBits'(1);
            for (int w = 0; w < PatWords; w++) begin
                r_word[w] <= '0;
            end
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ALPHABET_MODE:  r_mode    <= pwdata[ModeBits-1:0];
                REG_PATTERN_LENGTH: r_len     <= pwdata[LenBits-1:0];
                REG_PATTERN_WORD_0: r_word[0] <= pwdata;
                REG_PATTERN_WORD_1: r_word[1] <= pwdata;
                REG_PATTERN_WORD_2: r_word[2] <= pwdata;
                REG_PATTERN_WORD_3: r_word[3] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_ALPHABET_MODE:  prdata = DataBits'(r_mode);
            REG_PATTERN_LENGTH: prdata = DataBits'(r_len);
            REG_PATTERN_WORD_0: prdata = r_word[0];
            REG_PATTERN_WORD_1: prdata = r_word[1];
            REG_PATTERN_WORD_2: prdata = r_word[2];
            REG_PATTERN_WORD_3: prdata = r_word[3];
            default:            prdata = '0;
        endcase
    end

    // Length clamped to the window depth
    assign len_c = (r_len > LenBits'(PATTERN_MAX)) ? LenBits'(PATTERN_MAX) : r_len;

    assign o_ctrl.mode     = r_mode;
    assign o_ctrl.len_c    = len_c;
    assign o_ctrl.len_zero = (len_c == '0);
    assign o_ctrl.len_m1   = len_c - LenBits'(1);

    // Pattern reversed so that window entry j (newest first) meets byte len-1-j
    always_comb begin
        logic [LenBits-1:0] idx;
        idx = '0;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            idx = len_c - LenBits'(j) - LenBits'(1);
            n_mask[j] = (LenBits'(j) < len_c);
            n_pattern[j*8 +: 8] = n_mask[j] ? pat_all[idx[4:0]*8 +: 8] : 8'h00;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pattern <= n_pattern;
        r_mask    <= n_mask;
    end

    assign o_pattern = r_pattern;
    assign o_mask    = r_mask;

endmodule

// ===== hdl/rapf_core.sv =====
// Datapath: input register, symbol window, parallel compare and result register.
module rapf_core import rapf_pkg::*; #(
    parameter int PATTERN_MAX   = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_match_ctrl              i_ctrl,
    input  logic [PATTERN_MAX*8-1:0] i_pattern,
    input  logic [PATTERN_MAX-1:0]   i_mask,
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic [7:0]               i_base,
    input  logic                     i_strand,
    input  logic                     i_first,
    output logic                     o_m_valid,
    input  logic                     i_m_ready,
    output logic [OutPosBits-1:0]    o_position,
    output logic                     o_strand
);

    localparam int WinBits = PATTERN_MAX * 8;
    localparam int PosW    = (POSITION_BITS > OutPosBits) ? POSITION_BITS : OutPosBits;
    localparam logic [POSITION_BITS-1:0] PosMax = '1;
    localparam logic [LenBits-1:0]       FillMax = LenBits'(PATTERN_MAX);

    // Input register
    logic                     r_in_valid;
    logic [7:0]               r_base;
    logic                     r_strand;
    logic                     r_first;
    // Sequence state
    logic [WinBits-1:0]       r_win;
    logic [LenBits-1:0]       r_fill;
    logic [POSITION_BITS-1:0] r_pos;
    // Result register
    logic                     r_out_valid;
    logic [OutPosBits-1:0]    r_out_pos;
    logic                     r_out_strand;

    logic                     s_accept;
    logic                     advance;
    logic [7:0]               sym;
    logic [WinBits-1:0]       base_win;
    logic [WinBits-1:0]       n_win;
    logic [LenBits-1:0]       fill_base;
    logic [LenBits-1:0]       n_fill;
    logic [POSITION_BITS-1:0] pos_cur;
    logic [POSITION_BITS-1:0] n_pos;
    logic [PATTERN_MAX-1:0]   byte_ok;
    logic                     hit;
    logic [PosW-1:0]          start_w;

    // Handshake: the input register refills whenever its content moves on
    assign advance   = r_in_valid && (!r_out_valid || i_m_ready);
    assign o_s_ready = !r_in_valid || !r_out_valid || i_m_ready;
    assign s_accept  = i_s_valid && o_s_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_base   <= i_base;
            r_strand <= i_strand;
            r_first  <= i_first;
        end
    end

    // Encode and shift the window; a new sequence starts from a clear window
    assign sym       = encode_base(r_base, i_ctrl.mode);
    assign base_win  = r_first ? '0 : r_win;
    assign n_win     = (base_win << 8) | WinBits'(sym);
    assign fill_base = r_first ? '0 : r_fill;
    assign n_fill    = (fill_base == FillMax) ? fill_base : fill_base + LenBits'(1);
    assign pos_cur   = r_first ? '0 : r_pos;
    assign n_pos     = (pos_cur == PosMax) ? pos_cur : pos_cur + POSITION_BITS'(1);

    // Parallel byte compare against the aligned pattern
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            byte_ok[j] = !i_mask[j] || (n_win[j*8 +: 8] == i_pattern[j*8 +: 8]);
        end
    end

    assign hit     = !i_ctrl.len_zero && (n_fill >= i_ctrl.len_c) && (&byte_ok);
    assign start_w = PosW'(pos_cur) - PosW'(i_ctrl.len_m1);

    // Sequence state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_fill <= '0;
            r_pos  <= '0;
        end else if (advance) begin
            r_win  <= n_win;
            r_fill <= n_fill;
            r_pos  <= n_pos;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= hit;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pos    <= start_w[OutPosBits-1:0];
            r_out_strand <= r_strand;
        end
    end

    assign o_m_valid  = r_out_valid;
    assign o_position = r_out_pos;
    assign o_strand   = r_out_strand;

    // Fill count never runs past the window depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillMax)
        else $error("fill count beyond window depth");

    // Until the window fills, position and fill count advance together
    a_pos_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill < FillMax) |-> (r_pos == POSITION_BITS'(r_fill)))
        else $error("position out of step with fill count");

    // A processed item that matches leaves a result behind
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && hit) |=> r_out_valid)
        else $error("match lost");

    // A processed item that does not match leaves no result
    a_miss_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !hit) |=> !r_out_valid)
        else $error("result invented");

endmodule

// ===== hdl/reduced_alphabet_pattern_finder.sv =====
// Top level: reduced-alphabet sliding-window pattern finder with stream and APB-style ports.
// Takes one sequence byte per cycle on the slave stream and reports every occurrence of the
// configured pattern (1 to PATTERN_MAX bytes, overlaps included) as its zero-based start
// position and strand tag on the master stream. Throughput is one byte per clock while no result
// waits untaken; each byte passes the input register, then the window shift and
// parallel byte compare into the result register. Input ready drops only when both the input
// and result registers hold data and the result is not being taken. The aligned pattern is
// registered and is rebuilt in the cycle after a register write.
module reduced_alphabet_pattern_finder import rapf_pkg::*; #(
    parameter int PATTERN_MAX   = 32,
    parameter int POSITION_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Slave stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] base
    input  logic [1:0]          s_axis_tuser,   // [0] strand, [1] first
    // Master stream
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,   // [31:0] match_position
    output logic                m_axis_tuser,   // [0] match_strand
    // Configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AddrBits-1:0] paddr,
    input  logic [DataBits-1:0] pwdata,
    output logic [DataBits-1:0] prdata,
    output logic                pready
);

    t_match_ctrl              ctrl;
    logic [PATTERN_MAX*8-1:0] pattern;
    logic [PATTERN_MAX-1:0]   mask;

    // Configuration registers and aligned pattern
    rapf_cfg #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_ctrl    (ctrl),
        .o_pattern (pattern),
        .o_mask    (mask)
    );

    // Window and compare datapath
    rapf_core #(
        .PATTERN_MAX   (PATTERN_MAX),
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ctrl),
        .i_pattern  (pattern),
        .i_mask     (mask),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_base     (s_axis_tdata),
        .i_strand   (s_axis_tuser[0]),
        .i_first    (s_axis_tuser[1]),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_position (m_axis_tdata),
        .o_strand   (m_axis_tuser)
    );

endmodule

// ===== sim/reduced_alphabet_pattern_finder_tb.sv =====
// Testbench for the reduced-alphabet pattern finder: directed cases, then random sequences.
module reduced_alphabet_pattern_finder_tb import rapf_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // Modes with no reduction of their own
    localparam logic [ModeBits-1:0] MODE_UNUSED_ZERO = 3'd0;
    localparam logic [ModeBits-1:0] MODE_UNUSED_ONE  = 3'd1;
    localparam logic [ModeBits-1:0] MODE_UNUSED_FIVE = 3'd5;
    localparam logic [ModeBits-1:0] MODE_UNUSED_TOP  = 3'd7;

    localparam logic [7:0] CHR_N    = 8'h4e;
    localparam logic [7:0] CHR_UP_Z = 8'h5a;
    localparam int PHASES = 12;
    localparam int PHASE_ITEMS = 90;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [OutPosBits-1:0] pos;
        logic                  strand;
    } t_hit;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // [7:0] base
    logic [1:0]          s_axis_tuser = '0;   // [0] strand, [1] first
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;        // [31:0] match_position
    logic                m_axis_tuser;        // [0] match_strand
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [AddrBits-1:0] paddr = '0;
    logic [DataBits-1:0] pwdata = '0;
    logic [DataBits-1:0] prdata;
    logic                pready;

    // Model copy of the configuration
    logic [ModeBits-1:0]   cfg_mode = MODE_NO_REDUCTION;
    logic [LenBits-1:0]    cfg_len = 6'd1;
    logic [8*PatBytes-1:0] cfg_pattern = '0;

    // Model copy of the sequence state
    logic [7:0]            seq_window [PatBytes];
    logic [OutPosBits-1:0] seq_pos = '0;
    int                    seq_fill = 0;

    t_hit pending_hits [$];
    int   mismatch_count = 0;
    int   tx_gap_pct = 0;
    int   rx_stall_pct = 0;

    logic [7:0] plain_letters [5] = '{CHR_A, CHR_C, CHR_G, CHR_T, CHR_N};
    logic [ModeBits-1:0] phase_mode [PHASES] = '{
        MODE_NO_REDUCTION, MODE_TWO_LETTER, MODE_THREE_LETTER, MODE_THREE_LETTER,
        MODE_TWO_LETTER, MODE_NO_REDUCTION, MODE_UNUSED_TOP, MODE_UNUSED_ZERO,
        MODE_TWO_LETTER, MODE_THREE_LETTER, MODE_UNUSED_FIVE, MODE_UNUSED_ONE};
    logic [LenBits-1:0] phase_len [PHASES] = '{
        6'd1, 6'd2, 6'd3, 6'd32, 6'd4, 6'd63, 6'd5, 6'd2, 6'd33, 6'd6, 6'd3, 6'd0};

    reduced_alphabet_pattern_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("reduced_alphabet_pattern_finder_tb NOT OK");
        $finish;
    end

    // Result side back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end

    // Upper-case, then fold into the reduced alphabet of the current mode
    function automatic logic [7:0] fold_base(input logic [7:0] b);
        logic [7:0] u;
        u = (b >= CHR_LOW_A && b <= CHR_LOW_Z) ? b - CASE_GAP : b;
        unique case (cfg_mode)
            MODE_TWO_LETTER: begin
                if (u == CHR_A || u == CHR_G) return CHR_ZERO;
                if (u == CHR_C || u == CHR_T) return CHR_ONE;
            end
            MODE_THREE_LETTER: begin
                if (u == CHR_A) return CHR_ZERO;
                if (u == CHR_G) return CHR_ONE;
                if (u == CHR_C || u == CHR_T) return CHR_TWO;
            end
            default: ;
        endcase
        return u;
    endfunction

    // Take one request into the window and queue the occurrence it completes
    function automatic void predict_occurrence(input logic [7:0] b, input logic strand,
                                               input logic first);
        int span;
        logic hit;
        logic [OutPosBits-1:0] here;
        if (first) begin
            foreach (seq_window[i]) seq_window[i] = '0;
            seq_pos = '0;
            seq_fill = 0;
        end
        for (int i = PatBytes - 1; i > 0; i--) seq_window[i] = seq_window[i-1];
        seq_window[0] = fold_base(b);
        if (seq_fill < PatBytes) seq_fill++;
        here = seq_pos;
        if (seq_pos != '1) seq_pos++;
        span = (cfg_len > PatBytes) ? PatBytes : int'(cfg_len);
        hit = (span != 0) && (seq_fill >= span);
        for (int i = 0; i < span; i++) begin
            if (seq_window[span-1-i] != cfg_pattern[8*i +: 8]) hit = 1'b0;
        end
        if (hit) pending_hits.push_back('{pos: here - OutPosBits'(span - 1), strand: strand});
    endfunction

    // Compare each delivered occurrence with the oldest one predicted
    always @(posedge i_clk) begin : check_results
        t_hit want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: pos %0d strand %0d",
                             m_axis_tdata, m_axis_tuser);
            end else begin
                want = pending_hits.pop_front();
                if (m_axis_tdata !== want.pos || m_axis_tuser !== want.strand) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected pos %0d strand %0d, got %0d %0d",
                                 want.pos, want.strand, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // One APB transfer; a write also updates the model registers
    task automatic apb_xfer(input logic [2:0] idx, input logic wr, input logic [63:0] wdata,
                            output logic [63:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= AddrBits'({idx, 3'b000});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rdata = prdata;
        if (wr) begin
            unique case (idx)
                REG_ALPHABET_MODE:  cfg_mode = wdata[ModeBits-1:0];
                REG_PATTERN_LENGTH: cfg_len = wdata[LenBits-1:0];
                REG_PATTERN_WORD_0: cfg_pattern[0 +: 64] = wdata;
                REG_PATTERN_WORD_1: cfg_pattern[64 +: 64] = wdata;
                REG_PATTERN_WORD_2: cfg_pattern[128 +: 64] = wdata;
                REG_PATTERN_WORD_3: cfg_pattern[192 +: 64] = wdata;
                default: ;
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        logic [63:0] unused;
        apb_xfer(idx, 1'b1, value, unused);
    endtask

    // Offer one request, with a random gap first, and predict on acceptance
    task automatic send_base(input logic [7:0] b, input logic strand, input logic first);
        int gap;
        gap = 0;
        if (tx_gap_pct != 0)
            while ($urandom_range(99) < tx_gap_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {first, strand};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_occurrence(b, strand, first);
    endtask

    // Stop offering, drain every result and let the pipeline settle
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_pattern(input logic [ModeBits-1:0] mode, input logic [LenBits-1:0] len,
                               input logic [63:0] word0);
        drain_block();
        write_reg(REG_ALPHABET_MODE, 64'(mode));
        write_reg(REG_PATTERN_LENGTH, 64'(len));
        write_reg(REG_PATTERN_WORD_0, word0);
        @(posedge i_clk);
    endtask

    // Pattern symbol that some input can produce under the current mode
    function automatic logic [7:0] pick_symbol();
        unique case (cfg_mode)
            MODE_TWO_LETTER:   return $urandom_range(1) ? CHR_ONE : CHR_ZERO;
            MODE_THREE_LETTER: return CHR_ZERO + 8'($urandom_range(2));
            default: begin
                if ($urandom_range(9) == 0) return 8'($urandom);
                return plain_letters[$urandom_range(4)];
            end
        endcase
    endfunction

    // Random letter case for upper-case letters
    function automatic logic [7:0] vary_case(input logic [7:0] b);
        if (b >= CHR_A && b <= CHR_UP_Z && $urandom_range(1)) return b + CASE_GAP;
        return b;
    endfunction

    // A raw base that folds to the given symbol
    function automatic logic [7:0] base_for(input logic [7:0] sym);
        logic [7:0] b;
        b = sym;
        unique case (cfg_mode)
            MODE_TWO_LETTER: begin
                if (sym == CHR_ZERO) b = $urandom_range(1) ? CHR_A : CHR_G;
                else if (sym == CHR_ONE) b = $urandom_range(1) ? CHR_C : CHR_T;
            end
            MODE_THREE_LETTER: begin
                if (sym == CHR_ZERO) b = CHR_A;
                else if (sym == CHR_ONE) b = CHR_G;
                else if (sym == CHR_TWO) b = $urandom_range(1) ? CHR_C : CHR_T;
            end
            default: ;
        endcase
        return vary_case(b);
    endfunction

    // Defaults after reset: a one-byte pattern of zero
    task automatic test_reset_defaults();
        send_base(8'h00, 1'b0, 1'b1);
        send_base(8'hff, 1'b1, 1'b0);
        send_base(8'h00, 1'b1, 1'b0);
    endtask

    // Purine/pyrimidine folding with overlapping occurrences and lower case
    task automatic test_two_letter_overlap();
        set_pattern(MODE_TWO_LETTER, 6'd3, 64'({CHR_ZERO, CHR_ONE, CHR_ZERO}));
        send_base(CHR_A, 1'b0, 1'b1);
        send_base(CHR_C + CASE_GAP, 1'b1, 1'b0);
        send_base(CHR_G, 1'b0, 1'b0);
        send_base(CHR_T + CASE_GAP, 1'b1, 1'b0);
        send_base(CHR_G + CASE_GAP, 1'b1, 1'b0);
    endtask

    // Three-letter folding; a new sequence stops an occurrence across the boundary
    task automatic test_three_letter_restart();
        set_pattern(MODE_THREE_LETTER, 6'd3, 64'({CHR_TWO, CHR_ONE, CHR_ZERO}));
        send_base(CHR_A, 1'b0, 1'b1);
        send_base(CHR_G, 1'b0, 1'b0);
        send_base(CHR_C, 1'b1, 1'b1);
        send_base(CHR_A, 1'b1, 1'b0);
        send_base(CHR_G + CASE_GAP, 1'b0, 1'b0);
        send_base(CHR_T, 1'b1, 1'b0);
    endtask

    // Undefined mode passes bytes, non-letters compared as they are
    task automatic test_undefined_mode();
        set_pattern(MODE_UNUSED_FIVE, 6'd2, 64'({8'hff, CHR_A}));
        send_base(CHR_A + CASE_GAP, 1'b1, 1'b1);
        send_base(8'hff, 1'b0, 1'b0);
    endtask

    // An empty pattern never matches
    task automatic test_empty_pattern();
        set_pattern(MODE_NO_REDUCTION, 6'd0, 64'h0);
        send_base(8'h00, 1'b0, 1'b1);
        send_base(8'h00, 1'b1, 1'b0);
    endtask

    // Every register reads back what was written, mode and length cut to their field widths
    task automatic test_register_readback();
        logic [63:0] value [6];
        logic [63:0] got;
        logic [63:0] want;
        drain_block();
        foreach (value[i]) value[i] = {$urandom, $urandom};
        for (int i = 0; i < 6; i++) write_reg(3'(i), value[i]);
        for (int i = 0; i < 6; i++) begin
            apb_xfer(3'(i), 1'b0, '0, got);
            want = value[i];
            if (3'(i) == REG_ALPHABET_MODE) want = 64'(value[i][ModeBits-1:0]);
            if (3'(i) == REG_PATTERN_LENGTH) want = 64'(value[i][LenBits-1:0]);
            if (got !== want) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("register %0d read: expected %h, got %h", i, want, got);
            end
        end
    endtask

    // Random sequences under one configuration and one idling pattern
    task automatic test_random_phase(input int phase);
        logic [8*PatBytes-1:0] pat;
        int span;
        int sent;
        logic first;
        drain_block();
        unique case (phase % 4)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 59; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 59; end
            default: begin tx_gap_pct = 24; rx_stall_pct = 24; end
        endcase
        write_reg(REG_ALPHABET_MODE, {$urandom, $urandom} & ~64'h7 | 64'(phase_mode[phase]));
        write_reg(REG_PATTERN_LENGTH, 64'(phase_len[phase]));
        span = (phase_len[phase] > PatBytes) ? PatBytes : int'(phase_len[phase]);
        for (int i = 0; i < PatBytes; i++)
            pat[8*i +: 8] = (i < span) ? pick_symbol() : 8'($urandom);
        write_reg(REG_PATTERN_WORD_0, pat[0 +: 64]);
        write_reg(REG_PATTERN_WORD_1, pat[64 +: 64]);
        write_reg(REG_PATTERN_WORD_2, pat[128 +: 64]);
        write_reg(REG_PATTERN_WORD_3, pat[192 +: 64]);
        @(posedge i_clk);
        sent = 0;
        first = 1'b1;
        while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 10) begin
                // a planted occurrence, now and then cut by a new sequence
                for (int i = 0; i < span; i++) begin
                    send_base(base_for(cfg_pattern[8*i +: 8]), 1'($urandom),
                              first || ($urandom_range(199) == 0));
                    first = 1'b0;
                end
                sent += span;
            end else begin
                send_base(($urandom_range(99) < 15) ? 8'($urandom)
                                                    : vary_case(plain_letters[$urandom_range(4)]),
                          1'($urandom), first || ($urandom_range(99) < 2));
                first = 1'b0;
                sent++;
            end
            if (span == 0) sent++;
        end
    endtask

    initial begin
        foreach (seq_window[i]) seq_window[i] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_two_letter_overlap();
        test_three_letter_restart();
        test_undefined_mode();
        test_empty_pattern();
        test_register_readback();
        for (int p = 0; p < PHASES; p++) test_random_phase(p);
        drain_block();
        if (mismatch_count == 0) begin
            $display("reduced_alphabet_pattern_finder_tb OK");
        end else begin
            $display("reduced_alphabet_pattern_finder_tb NOT OK");
        end
        $finish;
    end

endmodule
